// File: hdl/wgs_pkg.sv
// waypoint goal sequencer package: command and cause codes, register
// indexes, reset values and the result descriptor shared by the modules
// no dependencies
`timescale 1ns / 1ps

package wgs_pkg;

  localparam int WGS_MAX_WAYPOINTS = 64;
  localparam int WGS_COORD_WIDTH   = 32;

  localparam int WGS_GOAL_W  = 32;
  localparam int WGS_SLOT_W  = 6;
  localparam int WGS_COUNT_W = 7;
  localparam int WGS_TOL_W   = 16;

  typedef enum logic [1:0] {
    CMD_LOAD   = 2'd0,
    CMD_SAMPLE = 2'd1,
    CMD_START  = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    CAUSE_START   = 2'd0,
    CAUSE_ADVANCE = 2'd1,
    CAUSE_RESEND  = 2'd2
  } cause_t;

  typedef enum logic [1:0] {
    REG_TARGET_COUNT    = 2'd0,
    REG_REACH_TOLERANCE = 2'd1,
    REG_STALL_TOLERANCE = 2'd2,
    REG_MOVE_THRESHOLD  = 2'd3
  } reg_idx_t;

  localparam logic [WGS_COUNT_W-1:0] RST_TARGET_COUNT    = 7'd1;
  localparam logic [WGS_TOL_W-1:0]   RST_REACH_TOLERANCE = 16'd1311;
  localparam logic [WGS_TOL_W-1:0]   RST_STALL_TOLERANCE = 16'd6554;
  localparam logic [WGS_TOL_W-1:0]   RST_MOVE_THRESHOLD  = 16'd3277;

  // result candidate leaving the control stage
  typedef struct packed {
    logic                  fixed;
    logic                  resend;
    logic [WGS_GOAL_W-1:0] goal_x;
    logic [WGS_GOAL_W-1:0] goal_y;
    logic [WGS_GOAL_W-1:0] goal_z;
    logic [WGS_SLOT_W-1:0] slot;
    cause_t                cause;
  } wgs_res_t;

endpackage

// File: hdl/wgs_table.sv
// waypoint table: synchronous memory, one write port, two registered read
// ports with write-to-read forwarding
// depends on nothing
`timescale 1ns / 1ps

module wgs_table #(
  parameter int DEPTH = 64,
  parameter int DW    = 96
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [DW-1:0]            wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic [DW-1:0]            rdata_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [DW-1:0]            rdata_b
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdq_a_r;
  logic [DW-1:0] rdq_b_r;
  logic [DW-1:0] byp_r;
  logic          hit_a_r;
  logic          hit_b_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdq_a_r <= mem[raddr_a];
    rdq_b_r <= mem[raddr_b];
    byp_r   <= wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_a_r <= 1'b0;
      hit_b_r <= 1'b0;
    end else begin
      hit_a_r <= we && (waddr == raddr_a);
      hit_b_r <= we && (waddr == raddr_b);
    end
  end

  assign rdata_a = hit_a_r ? byp_r : rdq_a_r;
  assign rdata_b = hit_b_r ? byp_r : rdq_b_r;

endmodule

// File: hdl/wgs_ctrl.sv
// control stage: goal, slot index and pose registers, arrival and far
// tests, table write and prefetch address
// depends on wgs_pkg
`timescale 1ns / 1ps

module wgs_ctrl
  import wgs_pkg::*;
#(
  parameter int MAX_WAYPOINTS = WGS_MAX_WAYPOINTS,
  parameter int COORD_WIDTH   = WGS_COORD_WIDTH
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             accept,
  input  logic [1:0]                       command,
  input  logic [WGS_SLOT_W-1:0]            slot,
  input  logic signed [COORD_WIDTH-1:0]    pos_x,
  input  logic signed [COORD_WIDTH-1:0]    pos_y,
  input  logic signed [COORD_WIDTH-1:0]    pos_z,
  input  logic [WGS_COUNT_W-1:0]           target_count,
  input  logic [WGS_TOL_W-1:0]             reach_tol,
  input  logic [WGS_TOL_W-1:0]             stall_tol,
  output logic                             tbl_we,
  output logic [$clog2(MAX_WAYPOINTS)-1:0] tbl_waddr,
  output logic [3*COORD_WIDTH-1:0]         tbl_wdata,
  output logic [$clog2(MAX_WAYPOINTS)-1:0] tbl_raddr,
  input  logic [3*COORD_WIDTH-1:0]         pf_next,
  input  logic [3*COORD_WIDTH-1:0]         pf_first,
  output logic                             push,
  output wgs_res_t                         res,
  output logic signed [COORD_WIDTH:0]      dx,
  output logic signed [COORD_WIDTH:0]      dy,
  output logic signed [COORD_WIDTH:0]      dz
);

  localparam int AW = $clog2(MAX_WAYPOINTS);
  localparam int CW = COORD_WIDTH;
  localparam int E  = COORD_WIDTH + 1;

  logic signed [CW-1:0]    goal_x_r, goal_y_r, goal_z_r;
  logic signed [CW-1:0]    goal_x_nxt, goal_y_nxt, goal_z_nxt;
  logic signed [CW-1:0]    last_x_r, last_y_r, last_z_r;
  logic signed [CW-1:0]    last_x_nxt, last_y_nxt, last_z_nxt;
  logic [WGS_COUNT_W-1:0]  next_slot_r, next_slot_nxt;
  logic                    running_r, running_nxt;

  logic [WGS_COUNT_W-1:0]  cnt;
  logic signed [CW-1:0]    nx, ny, nz, fx, fy, fz;
  logic signed [E-1:0]     ex, ey, ez;
  logic signed [E-1:0]     rt, st;
  logic                    reached, far, adv, resend_ok;
  logic [WGS_SLOT_W-1:0]   prev_slot;

  assign nx = signed'(pf_next[CW-1:0]);
  assign ny = signed'(pf_next[2*CW-1:CW]);
  assign nz = signed'(pf_next[3*CW-1:2*CW]);
  assign fx = signed'(pf_first[CW-1:0]);
  assign fy = signed'(pf_first[2*CW-1:CW]);
  assign fz = signed'(pf_first[3*CW-1:2*CW]);

  assign ex = E'(goal_x_r) - E'(pos_x);
  assign ey = E'(goal_y_r) - E'(pos_y);
  assign ez = E'(goal_z_r) - E'(pos_z);
  assign dx = E'(pos_x) - E'(last_x_r);
  assign dy = E'(pos_y) - E'(last_y_r);
  assign dz = E'(pos_z) - E'(last_z_r);

  assign rt = signed'(E'(reach_tol));
  assign st = signed'(E'(stall_tol));

  always_comb begin
    if (target_count == '0) begin
      cnt = 7'd1;
    end else if (32'(target_count) > MAX_WAYPOINTS) begin
      cnt = WGS_COUNT_W'(MAX_WAYPOINTS);
    end else begin
      cnt = target_count;
    end
  end

  assign reached = (ex < rt) && (ex > -rt) && (ey < rt) && (ey > -rt) &&
                   (ez < rt) && (ez > -rt);
  assign far = (ex >= st) || (ex <= -st) || (ey >= st) || (ey <= -st) ||
               (ez >= st) || (ez <= -st);
  assign adv = reached && (next_slot_r < cnt) && (32'(next_slot_r) < MAX_WAYPOINTS);
  assign resend_ok = far && (next_slot_r <= cnt);
  assign prev_slot = (next_slot_r == '0) ? '0 : WGS_SLOT_W'(next_slot_r - 7'd1);

  assign tbl_we    = accept && (command == CMD_LOAD) && (32'(slot) < MAX_WAYPOINTS);
  assign tbl_waddr = AW'(slot);
  assign tbl_wdata = {pos_z, pos_y, pos_x};
  assign tbl_raddr = AW'(next_slot_nxt);

  always_comb begin
    goal_x_nxt    = goal_x_r;
    goal_y_nxt    = goal_y_r;
    goal_z_nxt    = goal_z_r;
    last_x_nxt    = last_x_r;
    last_y_nxt    = last_y_r;
    last_z_nxt    = last_z_r;
    next_slot_nxt = next_slot_r;
    running_nxt   = running_r;
    push          = 1'b0;
    res.fixed     = 1'b0;
    res.resend    = 1'b0;
    res.goal_x    = WGS_GOAL_W'(goal_x_r);
    res.goal_y    = WGS_GOAL_W'(goal_y_r);
    res.goal_z    = WGS_GOAL_W'(goal_z_r);
    res.slot      = prev_slot;
    res.cause     = CAUSE_RESEND;
    if (accept) begin
      case (command)
        CMD_START: begin
          goal_x_nxt    = fx;
          goal_y_nxt    = fy;
          goal_z_nxt    = fz;
          last_x_nxt    = '0;
          last_y_nxt    = '0;
          last_z_nxt    = '0;
          next_slot_nxt = 7'd1;
          running_nxt   = 1'b1;
          push          = 1'b1;
          res.fixed     = 1'b1;
          res.goal_x    = WGS_GOAL_W'(fx);
          res.goal_y    = WGS_GOAL_W'(fy);
          res.goal_z    = WGS_GOAL_W'(fz);
          res.slot      = '0;
          res.cause     = CAUSE_START;
        end
        CMD_SAMPLE: begin
          if (running_r) begin
            last_x_nxt = pos_x;
            last_y_nxt = pos_y;
            last_z_nxt = pos_z;
            if (adv) begin
              goal_x_nxt    = nx;
              goal_y_nxt    = ny;
              goal_z_nxt    = nz;
              next_slot_nxt = next_slot_r + 7'd1;
              push          = 1'b1;
              res.fixed     = 1'b1;
              res.goal_x    = WGS_GOAL_W'(nx);
              res.goal_y    = WGS_GOAL_W'(ny);
              res.goal_z    = WGS_GOAL_W'(nz);
              res.slot      = next_slot_r[WGS_SLOT_W-1:0];
              res.cause     = CAUSE_ADVANCE;
            end else if (resend_ok) begin
              push       = 1'b1;
              res.resend = 1'b1;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      goal_x_r    <= '0;
      goal_y_r    <= '0;
      goal_z_r    <= '0;
      last_x_r    <= '0;
      last_y_r    <= '0;
      last_z_r    <= '0;
      next_slot_r <= '0;
      running_r   <= 1'b0;
    end else begin
      goal_x_r    <= goal_x_nxt;
      goal_y_r    <= goal_y_nxt;
      goal_z_r    <= goal_z_nxt;
      last_x_r    <= last_x_nxt;
      last_y_r    <= last_y_nxt;
      last_z_r    <= last_z_nxt;
      next_slot_r <= next_slot_nxt;
      running_r   <= running_nxt;
    end
  end

endmodule

// File: hdl/wgs_stall_pipe.sv
// movement pipeline: squares of the pose steps, stall compare, result
// filter and output register
// depends on wgs_pkg
`timescale 1ns / 1ps

module wgs_stall_pipe
  import wgs_pkg::*;
#(
  parameter int COORD_WIDTH = WGS_COORD_WIDTH
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        push,
  input  wgs_res_t                    res,
  input  logic signed [COORD_WIDTH:0] dx,
  input  logic signed [COORD_WIDTH:0] dy,
  input  logic signed [COORD_WIDTH:0] dz,
  input  logic [2*WGS_TOL_W-1:0]      thr2,
  output logic                        in_ready,
  output logic                        out_valid,
  input  logic                        out_ready,
  output wgs_res_t                    out_res
);

  localparam int QW = 2 * COORD_WIDTH + 1;
  localparam int PW = 2 * COORD_WIDTH + 2;
  localparam int SW = 2 * COORD_WIDTH + 3;

  logic                       s1_v_r;
  wgs_res_t                   s1_res_r;
  logic signed [COORD_WIDTH:0] s1_dx_r, s1_dy_r, s1_dz_r;
  logic                       s2_v_r;
  wgs_res_t                   s2_res_r;
  logic [QW-1:0]              s2_qx_r, s2_qy_r, s2_qz_r;
  logic                       out_v_r;
  wgs_res_t                   out_res_r;

  logic signed [PW-1:0]       px, py, pz;
  logic [SW-1:0]              moved;
  logic                       stalled, need_out, out_free, go2, s2_free, go1, s1_free;

  assign px = s1_dx_r * s1_dx_r;
  assign py = s1_dy_r * s1_dy_r;
  assign pz = s1_dz_r * s1_dz_r;

  assign moved    = SW'(s2_qx_r) + SW'(s2_qy_r) + SW'(s2_qz_r);
  assign stalled  = moved <= SW'(thr2);
  assign need_out = s2_res_r.fixed || (s2_res_r.resend && stalled);

  assign out_free = !out_v_r || out_ready;
  assign go2      = s2_v_r && (!need_out || out_free);
  assign s2_free  = !s2_v_r || go2;
  assign go1      = s1_v_r && s2_free;
  assign s1_free  = !s1_v_r || go1;
  assign in_ready = s1_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (s1_free) begin
        s1_v_r <= push;
      end
      if (s2_free) begin
        s2_v_r <= s1_v_r;
      end
      if (out_free) begin
        out_v_r <= go2 && need_out;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_free) begin
      s1_res_r <= res;
      s1_dx_r  <= dx;
      s1_dy_r  <= dy;
      s1_dz_r  <= dz;
    end
    if (s2_free) begin
      s2_res_r <= s1_res_r;
      s2_qx_r  <= px[QW-1:0];
      s2_qy_r  <= py[QW-1:0];
      s2_qz_r  <= pz[QW-1:0];
    end
    if (out_free) begin
      out_res_r <= s2_res_r;
    end
  end

  assign out_valid = out_v_r;
  assign out_res   = out_res_r;

endmodule

// File: hdl/waypoint_goal_sequencer_top.sv
// waypoint goal sequencer top: configuration registers, stream ports,
// waypoint table, control stage and movement pipeline
// depends on wgs_pkg, wgs_table, wgs_ctrl, wgs_stall_pipe
//
//   channel  dir  handshake            payload
//   in_      in   in_tvalid/in_tready   tuser command, tdata slot and pose
//   out_     out  out_tvalid/out_tready tuser cause, tdata goal and slot
//   cfg_     in   cfg_we                cfg_index, cfg_wdata
//
// one word per cycle in while in_tready is high; a goal word passes the s1,
// s2 and output registers; the next-waypoint and first-waypoint reads come
// from the table's two prefetch ports, so an advance waits on no table read
// reset is synchronous and clears control state only; the table holds no
// valid bits and needs no clearing pass
// a stalled output holds its word while the pipeline keeps filling its
// free stages
`timescale 1ns / 1ps

module waypoint_goal_sequencer_top
  import wgs_pkg::*;
#(
  parameter int MAX_WAYPOINTS = WGS_MAX_WAYPOINTS,
  parameter int COORD_WIDTH   = WGS_COORD_WIDTH
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [103:0]         in_tdata,   // slot, pos_x, pos_y, pos_z
  input  logic [1:0]           in_tuser,   // command
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [103:0]         out_tdata,  // goal_x, goal_y, goal_z, goal_slot
  output logic [1:0]           out_tuser,  // cause
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_index,
  input  logic [WGS_TOL_W-1:0] cfg_wdata
);

  localparam int AW = $clog2(MAX_WAYPOINTS);
  localparam int DW = 3 * COORD_WIDTH;

  logic [WGS_COUNT_W-1:0]   target_count_r;
  logic [WGS_TOL_W-1:0]     reach_tol_r, stall_tol_r, move_thr_r;
  logic [2*WGS_TOL_W-1:0]   thr2_r;

  logic                     accept;
  logic signed [COORD_WIDTH-1:0] pos_x, pos_y, pos_z;
  logic                     tbl_we;
  logic [AW-1:0]            tbl_waddr, tbl_raddr;
  logic [DW-1:0]            tbl_wdata, pf_next, pf_first;
  logic                     push;
  wgs_res_t                 res, out_res;
  logic signed [COORD_WIDTH:0] dx, dy, dz;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_count_r <= RST_TARGET_COUNT;
      reach_tol_r    <= RST_REACH_TOLERANCE;
      stall_tol_r    <= RST_STALL_TOLERANCE;
      move_thr_r     <= RST_MOVE_THRESHOLD;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TARGET_COUNT:    target_count_r <= cfg_wdata[WGS_COUNT_W-1:0];
        REG_REACH_TOLERANCE: reach_tol_r    <= cfg_wdata;
        REG_STALL_TOLERANCE: stall_tol_r    <= cfg_wdata;
        REG_MOVE_THRESHOLD:  move_thr_r     <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    thr2_r <= move_thr_r * move_thr_r;
  end

  assign accept = in_tvalid && in_tready;
  assign pos_x  = signed'(in_tdata[6 +: COORD_WIDTH]);
  assign pos_y  = signed'(in_tdata[38 +: COORD_WIDTH]);
  assign pos_z  = signed'(in_tdata[70 +: COORD_WIDTH]);

  wgs_table #(
    .DEPTH (MAX_WAYPOINTS),
    .DW    (DW)
  ) u_table (
    .clk     (clk),
    .rst_n   (rst_n),
    .we      (tbl_we),
    .waddr   (tbl_waddr),
    .wdata   (tbl_wdata),
    .raddr_a (tbl_raddr),
    .rdata_a (pf_next),
    .raddr_b ('0),
    .rdata_b (pf_first)
  );

  wgs_ctrl #(
    .MAX_WAYPOINTS (MAX_WAYPOINTS),
    .COORD_WIDTH   (COORD_WIDTH)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (accept),
    .command      (in_tuser),
    .slot         (in_tdata[5:0]),
    .pos_x        (pos_x),
    .pos_y        (pos_y),
    .pos_z        (pos_z),
    .target_count (target_count_r),
    .reach_tol    (reach_tol_r),
    .stall_tol    (stall_tol_r),
    .tbl_we       (tbl_we),
    .tbl_waddr    (tbl_waddr),
    .tbl_wdata    (tbl_wdata),
    .tbl_raddr    (tbl_raddr),
    .pf_next      (pf_next),
    .pf_first     (pf_first),
    .push         (push),
    .res          (res),
    .dx           (dx),
    .dy           (dy),
    .dz           (dz)
  );

  wgs_stall_pipe #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_pipe (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .res       (res),
    .dx        (dx),
    .dy        (dy),
    .dz        (dz),
    .thr2      (thr2_r),
    .in_ready  (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (out_res)
  );

  assign out_tdata = {2'b00, out_res.slot, out_res.goal_z, out_res.goal_y, out_res.goal_x};
  assign out_tuser = out_res.cause;

endmodule
